### rtl/vref_pkg.sv
// Shared widths for the vector refraction datapath.
package vref_pkg;

    // Width of every vector component at the ports
    localparam int DATA_W = 16;
    // Width of a saturated perpendicular component (limit is +-2^30)
    localparam int PERP_W = 32;
    // Width of squares, squared length and the square-root radicand
    localparam int SQ_W   = 64;
    // Bits of the square root; one pipeline stage per bit
    localparam int ROOT_W = 31;

    typedef logic signed [DATA_W-1:0] comp_t;

endpackage

### rtl/vector_refraction.sv
// Pipelined Snell's-law refraction of a direction vector in signed fixed point.

// Takes one transaction per cycle while item_stall is low. Each result passes
// through 8 stages for the dot product, the perpendicular part and its squared
// length, 31 stages for the square root (one root bit per stage), 1 stage for
// the normal scaling and 1 output stage. The whole pipeline holds while an
// output transaction is stalled, so item_stall follows result_stall whenever a
// result is waiting. Rounding drops FRAC_BITS fraction bits, half toward plus
// infinity. clipped flags saturation of a perpendicular component or of an
// output component.
module vector_refraction #(
    parameter int FRAC_BITS = 14
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  logic signed [vref_pkg::DATA_W-1:0] inc_x,
    input  logic signed [vref_pkg::DATA_W-1:0] inc_y,
    input  logic signed [vref_pkg::DATA_W-1:0] inc_z,
    input  logic signed [vref_pkg::DATA_W-1:0] nrm_x,
    input  logic signed [vref_pkg::DATA_W-1:0] nrm_y,
    input  logic signed [vref_pkg::DATA_W-1:0] nrm_z,
    input  logic        [vref_pkg::DATA_W-1:0] eta_ratio,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic signed [vref_pkg::DATA_W-1:0] out_x,
    output logic signed [vref_pkg::DATA_W-1:0] out_y,
    output logic signed [vref_pkg::DATA_W-1:0] out_z,
    output logic                               clipped
);

    localparam int DW     = vref_pkg::DATA_W;
    localparam int PW     = vref_pkg::PERP_W;
    localparam int SW     = vref_pkg::SQ_W;
    localparam int RW     = vref_pkg::ROOT_W;
    localparam int PROD_W = 2 * DW;
    localparam int DOT_W  = PROD_W + 2;
    localparam int M_W    = DW + DOT_W;
    localparam int U_W    = M_W + 1;
    localparam int PE_W   = U_W + DW + 1;
    localparam int NS_W   = DW + RW + 1;
    localparam int V_W    = NS_W + 1;
    localparam int NSTG   = 8 + RW + 2;

    localparam logic signed [DOT_W-1:0] HALF_D = DOT_W'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [DOT_W-1:0] ONE_D  = DOT_W'(64'd1 << FRAC_BITS);
    localparam logic signed [M_W-1:0]   HALF_M = M_W'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [PE_W-1:0]  HALF_P = PE_W'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [PE_W-1:0]  PLIM_P = PE_W'(64'd1 << 30);
    localparam logic signed [PE_W-1:0]  NLIM_P = -PLIM_P;
    localparam logic signed [NS_W-1:0]  HALF_N = NS_W'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [SW-1:0]    ONE_SQ = SW'(64'd1 << (2 * FRAC_BITS));
    localparam logic signed [V_W-1:0]   OMAX   = V_W'(32767);
    localparam logic signed [V_W-1:0]   OMIN   = -V_W'(32768);

    logic             adv;
    logic [NSTG-1:0]  valid_reg;

    // input staging
    vref_pkg::comp_t inc_in [3];
    vref_pkg::comp_t nrm_in [3];

    // stage 1: products of incident and normal
    logic signed [PROD_W-1:0] prod1_reg [3];
    vref_pkg::comp_t          inc1_reg  [3];
    vref_pkg::comp_t          nrm1_reg  [3];
    logic [DW-1:0]            eta1_reg;

    // stage 2: clamped cosine
    logic signed [DOT_W-1:0]  cos2_reg;
    logic signed [DOT_W-1:0]  dot2, cosr2;
    vref_pkg::comp_t          inc2_reg  [3];
    vref_pkg::comp_t          nrm2_reg  [3];
    logic [DW-1:0]            eta2_reg;

    // stage 3: normal times cosine
    logic signed [M_W-1:0]    m3_reg    [3];
    vref_pkg::comp_t          inc3_reg  [3];
    vref_pkg::comp_t          nrm3_reg  [3];
    logic [DW-1:0]            eta3_reg;

    // stage 4: unscaled perpendicular part
    logic signed [U_W-1:0]    u4_reg    [3];
    vref_pkg::comp_t          nrm4_reg  [3];
    logic [DW-1:0]            eta4_reg;

    // stage 5: scaled by eta
    logic signed [PE_W-1:0]   pe5_reg   [3];
    vref_pkg::comp_t          nrm5_reg  [3];

    // stage 6: rounded and saturated perpendicular part
    logic signed [PW-1:0]     perp6_reg [3];
    logic signed [PE_W-1:0]   per6      [3];
    logic [2:0]               psat6;
    logic                     clip6_reg;
    vref_pkg::comp_t          nrm6_reg  [3];

    // stage 7: squares
    logic signed [SW-1:0]     sq7_reg   [3];
    logic signed [PW-1:0]     perp7_reg [3];
    logic                     clip7_reg;
    vref_pkg::comp_t          nrm7_reg  [3];

    // stage 8: radicand
    logic [SW-1:0]            x8_reg;
    logic signed [SW-1:0]     diff8;
    logic signed [PW-1:0]     perp8_reg [3];
    logic                     clip8_reg;
    vref_pkg::comp_t          nrm8_reg  [3];

    // square-root stages
    logic [SW-1:0]            sx_reg    [RW];
    logic [SW-1:0]            sr_reg    [RW];
    logic signed [PW-1:0]     sperp_reg [RW][3];
    vref_pkg::comp_t          snrm_reg  [RW][3];
    logic                     sclip_reg [RW];

    // normal times root
    logic signed [NS_W-1:0]   ns_reg    [3];
    logic signed [PW-1:0]     perpn_reg [3];
    logic                     clipn_reg;

    // output stage
    logic signed [V_W-1:0]    vo        [3];
    logic [2:0]               osat;
    vref_pkg::comp_t          out_reg   [3];
    logic                     clip_out_reg;

    assign inc_in[0] = inc_x;
    assign inc_in[1] = inc_y;
    assign inc_in[2] = inc_z;
    assign nrm_in[0] = nrm_x;
    assign nrm_in[1] = nrm_y;
    assign nrm_in[2] = nrm_z;

    // hold the whole pipeline while a result waits
    assign adv        = !(valid_reg[NSTG-1] && result_stall);
    assign item_stall = !adv;

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[NSTG-2:0], item_valid};
        end
    end

    // cosine and clamp
    always_comb
    begin
        dot2  = -(DOT_W'(prod1_reg[0]) + DOT_W'(prod1_reg[1]) + DOT_W'(prod1_reg[2]));
        cosr2 = (dot2 + HALF_D) >>> FRAC_BITS;
    end

    // perpendicular saturation and radicand
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            per6[k]  = (pe5_reg[k] + HALF_P) >>> FRAC_BITS;
            psat6[k] = (per6[k] > PLIM_P) || (per6[k] < NLIM_P);
        end
        diff8 = ONE_SQ - (sq7_reg[0] + sq7_reg[1] + sq7_reg[2]);
    end

    // output rounding and saturation
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            vo[k]   = V_W'(perpn_reg[k]) - V_W'((ns_reg[k] + HALF_N) >>> FRAC_BITS);
            osat[k] = (vo[k] > OMAX) || (vo[k] < OMIN);
        end
    end

    // front stages: dot product through squared length
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod1_reg[k] <= inc_in[k] * nrm_in[k];
                inc1_reg[k]  <= inc_in[k];
                nrm1_reg[k]  <= nrm_in[k];
                inc2_reg[k]  <= inc1_reg[k];
                nrm2_reg[k]  <= nrm1_reg[k];
                m3_reg[k]    <= M_W'(nrm2_reg[k]) * M_W'(cos2_reg);
                inc3_reg[k]  <= inc2_reg[k];
                nrm3_reg[k]  <= nrm2_reg[k];
                u4_reg[k]    <= U_W'(inc3_reg[k])
                              + U_W'((m3_reg[k] + HALF_M) >>> FRAC_BITS);
                nrm4_reg[k]  <= nrm3_reg[k];
                pe5_reg[k]   <= PE_W'(u4_reg[k]) * PE_W'($signed({1'b0, eta4_reg}));
                nrm5_reg[k]  <= nrm4_reg[k];
                if (per6[k] > PLIM_P)
                begin
                    perp6_reg[k] <= PW'(PLIM_P);
                end
                else if (per6[k] < NLIM_P)
                begin
                    perp6_reg[k] <= PW'(NLIM_P);
                end
                else
                begin
                    perp6_reg[k] <= PW'(per6[k]);
                end
                nrm6_reg[k]  <= nrm5_reg[k];
                sq7_reg[k]   <= SW'(perp6_reg[k]) * SW'(perp6_reg[k]);
                perp7_reg[k] <= perp6_reg[k];
                nrm7_reg[k]  <= nrm6_reg[k];
                perp8_reg[k] <= perp7_reg[k];
                nrm8_reg[k]  <= nrm7_reg[k];
            end
            eta1_reg  <= eta_ratio;
            eta2_reg  <= eta1_reg;
            eta3_reg  <= eta2_reg;
            eta4_reg  <= eta3_reg;
            cos2_reg  <= (cosr2 > ONE_D) ? ONE_D : cosr2;
            clip6_reg <= |psat6;
            clip7_reg <= clip6_reg;
            clip8_reg <= clip7_reg;
            x8_reg    <= (diff8 < 0) ? SW'(-diff8) : SW'(diff8);
        end
    end

    // square root, one result bit per stage
    for (genvar j = 0; j < RW; j++)
    begin : g_root
        localparam logic [SW-1:0] BIT = SW'(64'd1 << (2 * (RW - 1 - j)));
        logic [SW-1:0]            x_in, r_in, trial;
        logic signed [PW-1:0]     p_in [3];
        vref_pkg::comp_t          n_in [3];
        logic                     c_in;

        if (j == 0)
        begin : g_first
            assign x_in = x8_reg;
            assign r_in = '0;
            assign p_in = perp8_reg;
            assign n_in = nrm8_reg;
            assign c_in = clip8_reg;
        end
        else
        begin : g_next
            assign x_in = sx_reg[j-1];
            assign r_in = sr_reg[j-1];
            assign p_in = sperp_reg[j-1];
            assign n_in = snrm_reg[j-1];
            assign c_in = sclip_reg[j-1];
        end

        assign trial = r_in + BIT;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (x_in >= trial)
                begin
                    sx_reg[j] <= x_in - trial;
                    sr_reg[j] <= (r_in >> 1) + BIT;
                end
                else
                begin
                    sx_reg[j] <= x_in;
                    sr_reg[j] <= r_in >> 1;
                end
                sperp_reg[j] <= p_in;
                snrm_reg[j]  <= n_in;
                sclip_reg[j] <= c_in;
            end
        end
    end

    // back stages: parallel part and output
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ns_reg[k]    <= NS_W'(snrm_reg[RW-1][k])
                              * NS_W'($signed({1'b0, sr_reg[RW-1][RW-1:0]}));
                perpn_reg[k] <= sperp_reg[RW-1][k];
                if (vo[k] > OMAX)
                begin
                    out_reg[k] <= DW'(OMAX);
                end
                else if (vo[k] < OMIN)
                begin
                    out_reg[k] <= DW'(OMIN);
                end
                else
                begin
                    out_reg[k] <= DW'(vo[k]);
                end
            end
            clipn_reg    <= sclip_reg[RW-1];
            clip_out_reg <= clipn_reg || (|osat);
        end
    end

    assign result_valid = valid_reg[NSTG-1];
    assign out_x        = out_reg[0];
    assign out_y        = out_reg[1];
    assign out_z        = out_reg[2];
    assign clipped      = clip_out_reg;

endmodule

### tb/tb_top.sv
// Testbench for vector_refraction: random and directed rays checked against a local predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int  FRAC      = 14;
    localparam longint ONE_FX = longint'(1) << FRAC;
    localparam longint PERP_LIM = longint'(1) << 30;
    localparam int  N_RANDOM  = 430;
    localparam int  LONG_HOLD = 300;

    typedef struct {
        vref_pkg::comp_t ix, iy, iz, nx, ny, nz;
        logic [15:0]     eta;
        bit              drain;   // wait for every result before this one goes out
    } ray_t;

    typedef struct {
        vref_pkg::comp_t x, y, z;
        logic            clip;
    } refr_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    vref_pkg::comp_t inc_x = '0, inc_y = '0, inc_z = '0;
    vref_pkg::comp_t nrm_x = '0, nrm_y = '0, nrm_z = '0;
    logic [15:0] eta_ratio = '0;
    logic result_valid;
    logic result_stall = 1'b1;
    vref_pkg::comp_t out_x, out_y, out_z;
    logic clipped;

    ray_t  pending_rays[$];
    refr_t expected_refr[$];
    int    n_errors = 0;
    int    n_sent = 0;
    int    n_checked = 0;
    int    n_clipped = 0;
    bit    stim_done = 1'b0;
    bit    long_hold_done = 1'b0;

    vector_refraction u_top (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall),
        .inc_x(inc_x), .inc_y(inc_y), .inc_z(inc_z),
        .nrm_x(nrm_x), .nrm_y(nrm_y), .nrm_z(nrm_z),
        .eta_ratio(eta_ratio),
        .result_valid(result_valid), .result_stall(result_stall),
        .out_x(out_x), .out_y(out_y), .out_z(out_z), .clipped(clipped)
    );

    always #1 clk = ~clk;

    // Drop FRAC bits, half toward plus infinity
    function automatic longint fx_round(longint v);
        return (v + (longint'(1) << (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi, ref bit clip);
        if (v > hi)
        begin
            clip = 1'b1;
            return hi;
        end
        if (v < lo)
        begin
            clip = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Refracted direction of one ray
    function automatic refr_t refract_predict(ray_t ray);
        longint inc[3];
        longint nrm[3];
        longint perp[3];
        longint o[3];
        longint eta, dot, cosv, u, diff;
        longint unsigned len2, s;
        bit clip;
        refr_t res;
        inc[0] = longint'(ray.ix); inc[1] = longint'(ray.iy); inc[2] = longint'(ray.iz);
        nrm[0] = longint'(ray.nx); nrm[1] = longint'(ray.ny); nrm[2] = longint'(ray.nz);
        eta = longint'({48'd0, ray.eta});
        clip = 1'b0;
        dot = 0;
        for (int k = 0; k < 3; k++)
            dot = dot - inc[k] * nrm[k];
        cosv = fx_round(dot);
        if (cosv > ONE_FX)
            cosv = ONE_FX;
        len2 = 0;
        for (int k = 0; k < 3; k++)
        begin
            u = inc[k] + fx_round(nrm[k] * cosv);
            perp[k] = clamp(fx_round(u * eta), -PERP_LIM, PERP_LIM, clip);
            len2 = len2 + longint'(perp[k] * perp[k]);
        end
        diff = (longint'(1) << (2 * FRAC)) - longint'(len2);
        if (diff < 0)
            diff = -diff;
        s = root_floor(diff);
        for (int k = 0; k < 3; k++)
            o[k] = clamp(perp[k] - fx_round(nrm[k] * longint'(s)), -32768, 32767, clip);
        res.x = vref_pkg::comp_t'(o[0]);
        res.y = vref_pkg::comp_t'(o[1]);
        res.z = vref_pkg::comp_t'(o[2]);
        res.clip = clip;
        return res;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        n_errors++;
    endtask

    task automatic add_ray(int ix, int iy, int iz, int nx, int ny, int nz, int eta,
                           bit drain);
        ray_t r;
        r.ix = vref_pkg::comp_t'(ix);
        r.iy = vref_pkg::comp_t'(iy);
        r.iz = vref_pkg::comp_t'(iz);
        r.nx = vref_pkg::comp_t'(nx);
        r.ny = vref_pkg::comp_t'(ny);
        r.nz = vref_pkg::comp_t'(nz);
        r.eta = eta[15:0];
        r.drain = drain;
        pending_rays.push_back(r);
    endtask

    // Random direction of given length in Q2.14
    task automatic rand_dir(real len, output int cx, output int cy, output int cz);
        real a, b, c, m;
        a = (real'($urandom_range(0, 20000)) - 10000.0) / 10000.0;
        b = (real'($urandom_range(0, 20000)) - 10000.0) / 10000.0;
        c = (real'($urandom_range(0, 20000)) - 10000.0) / 10000.0;
        m = $sqrt(a * a + b * b + c * c);
        if (m < 0.01)
        begin
            a = 1.0; m = 1.0;
        end
        cx = int'(a / m * len * 16384.0);
        cy = int'(b / m * len * 16384.0);
        cz = int'(c / m * len * 16384.0);
    endtask

    // Driver: offer pending rays with random gaps
    int send_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        ray_t  nxt;
        bit    accepted;
        bit    can_go;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            accepted = item_valid && !item_stall;
            if (accepted)
            begin
                nxt.ix = inc_x; nxt.iy = inc_y; nxt.iz = inc_z;
                nxt.nx = nrm_x; nxt.ny = nrm_y; nxt.nz = nrm_z;
                nxt.eta = eta_ratio;
                nxt.drain = 1'b0;
                expected_refr.push_back(refract_predict(nxt));
                n_sent++;
            end
            if (accepted || !item_valid)
            begin
                can_go = pending_rays.size() != 0 && send_gap == 0;
                if (can_go && pending_rays[0].drain && (expected_refr.size() != 0 || accepted))
                    can_go = 1'b0;
                if (send_gap > 0)
                    send_gap <= send_gap - 1;
                if (can_go)
                begin
                    nxt = pending_rays.pop_front();
                    inc_x <= nxt.ix; inc_y <= nxt.iy; inc_z <= nxt.iz;
                    nrm_x <= nxt.nx; nrm_y <= nxt.ny; nrm_z <= nxt.nz;
                    eta_ratio <= nxt.eta;
                    item_valid <= 1'b1;
                    send_gap <= ((n_sent / 60) % 3 == 1) ? 0 : $urandom_range(0, 14);
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transaction and pace the stall
    int recv_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        refr_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b1;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_refr.size() == 0)
                begin
                    report("unexpected result", 1, 0);
                end
                else
                begin
                    want = expected_refr.pop_front();
                    if (out_x !== want.x) report("out_x", out_x, want.x);
                    if (out_y !== want.y) report("out_y", out_y, want.y);
                    if (out_z !== want.z) report("out_z", out_z, want.z);
                    if (clipped !== want.clip) report("clipped", clipped, want.clip);
                    if (want.clip) n_clipped++;
                end
                n_checked++;
            end
            if (!long_hold_done && n_sent >= 120)
            begin
                // hold off long enough for the pipeline to fill and push back
                long_hold_done <= 1'b1;
                recv_gap <= LONG_HOLD;
                result_stall <= 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
                if (result_valid)
                    recv_gap <= ((n_checked / 50) % 3 == 2) ? 0 : $urandom_range(0, 14);
            end
        end
    end

    initial
    begin
        int ax, ay, az, bx, by, bz, eta;
        // directed: extremes and special cases
        add_ray(0, 0, 0, 0, 0, 0, 0, 1'b0);
        add_ray(32767, 32767, 32767, 32767, 32767, 32767, 65535, 1'b0);
        add_ray(-32768, -32768, -32768, -32768, -32768, -32768, 65535, 1'b0);
        add_ray(-32768, -32768, -32768, 32767, 32767, 32767, 65535, 1'b0);
        add_ray(32767, -32768, 32767, -32768, 32767, -32768, 0, 1'b0);
        add_ray(0, 0, -16384, 0, 0, 16384, 16384, 1'b0);       // head-on
        add_ray(0, 11585, -11585, 0, 0, 16384, 16384, 1'b0);   // 45 degrees, no bend
        add_ray(0, 11585, -11585, 0, 0, 16384, 10923, 1'b0);   // into glass
        add_ray(0, 11585, -11585, 0, 0, 16384, 24576, 1'b0);   // total internal reflection
        add_ray(0, 16300, -1600, 0, 0, 16384, 32767, 1'b0);    // grazing, strong TIR
        add_ray(16384, 0, 0, 16384, 0, 0, 16384, 1'b0);        // ray along the normal, cosine minus one
        add_ray(0, 0, 16384, 0, 0, 16384, 16384, 1'b0);        // from behind
        add_ray(32767, 0, 0, -32768, 0, 0, 65535, 1'b0);       // cosine clamped at one
        add_ray(20000, 20000, 0, -20000, 0, 0, 65535, 1'b0);   // output overflow
        add_ray(8000, -3000, 100, 4000, 4000, 4000, 40000, 1'b0); // non-unit
        add_ray(1, -1, 1, -1, 1, -1, 1, 1'b0);
        add_ray(-1, -1, -1, -1, -1, -1, 32768, 1'b0);
        add_ray(0, 0, -16384, 0, 0, 16384, 0, 1'b1);           // after a full drain
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                rand_dir(1.0, ax, ay, az);
                rand_dir(1.0, bx, by, bz);
                // face the normal against the ray most of the time
                if ((ax * bx + ay * by + az * bz) > 0 && $urandom_range(0, 4) != 0)
                begin
                    bx = -bx; by = -by; bz = -bz;
                end
                eta = $urandom_range(8192, 32768);
            end
            else
            begin
                ax = $urandom_range(0, 65535); ay = $urandom_range(0, 65535);
                az = $urandom_range(0, 65535); bx = $urandom_range(0, 65535);
                by = $urandom_range(0, 65535); bz = $urandom_range(0, 65535);
                eta = $urandom_range(0, 65535);
            end
            add_ray(ax, ay, az, bx, by, bz, eta, i == 250);
        end
        stim_done = 1'b1;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done);
        wait (pending_rays.size() == 0 && !item_valid);
        wait (expected_refr.size() == 0);
        repeat (60) @(posedge clk);
        $display("sent %0d rays, checked %0d refractions, %0d clipped",
                 n_sent, n_checked, n_clipped);
        $display("covered extremes, total internal reflection, overflow and back-pressure");
        if (n_errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout with %0d results outstanding", expected_refr.size());
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
